### rtl/xtea_block_cipher_assert.svh
// ----------------------------------------------------------------------------
// XTEA block cipher assertion macros
// Shared macros for the concurrent checks in the cipher RTL. The user module
// must provide clk and arst_n.
// ----------------------------------------------------------------------------
`ifndef XTEA_BLOCK_CIPHER_ASSERT_SVH
`define XTEA_BLOCK_CIPHER_ASSERT_SVH

// Check a property on every rising edge outside of reset.
`define XTEA_ASSERT(lbl, prop, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (prop)) else $error(msg);

// Check that a condition in one cycle implies another in the next cycle.
`define XTEA_ASSERT_NEXT(lbl, cond, expct, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (cond) |=> (expct)) \
		else $error(msg);

`endif

### rtl/xtea_pkg.sv
// ----------------------------------------------------------------------------
// XTEA package
// Constants, register indexes and shared types for the XTEA block cipher.
// ----------------------------------------------------------------------------
package xtea_pkg;

	// Cipher constants.
	localparam logic [31:0] XTEA_DELTA     = 32'h9E3779B9;
	localparam logic [7:0]  ROUNDS_RESET   = 8'd32;
	// Decryption start sum for the reset round count (delta times 32).
	localparam logic [31:0] DEC_SUM_RESET  = 32'hC6EF3720;

	// Configuration register indexes.
	localparam logic [2:0] REG_KEY_A  = 3'd0;
	localparam logic [2:0] REG_KEY_B  = 3'd1;
	localparam logic [2:0] REG_KEY_C  = 3'd2;
	localparam logic [2:0] REG_KEY_D  = 3'd3;
	localparam logic [2:0] REG_ROUNDS = 3'd4;

	// Request types carried on tuser.
	localparam logic REQ_ENCRYPT = 1'b0;
	localparam logic REQ_DECRYPT = 1'b1;

	// Configuration seen by the datapath.
	typedef struct packed {
		logic [3:0][31:0] key;
		logic [7:0]       rounds;
		logic [31:0]      dec_sum;
	} cfg_t;

endpackage

### rtl/xtea_cfg.sv
// ----------------------------------------------------------------------------
// XTEA configuration registers
// Holds the 128-bit key and the round count, and keeps the decryption start
// sum (delta times the round count) ready whenever the count is written.
// ----------------------------------------------------------------------------
module xtea_cfg (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               cfg_we,
	input  logic [2:0]         cfg_addr,
	input  logic [31:0]        cfg_wdata,
	output xtea_pkg::cfg_t     cfg
);

	logic [3:0][31:0] key_q;
	logic [7:0]       rounds_q;
	logic [31:0]      dec_sum_q;
	logic [31:0]      dec_sum_next;

	// Start sum for decryption, one narrow multiply at write time.
	assign dec_sum_next = 32'(xtea_pkg::XTEA_DELTA * {24'd0, cfg_wdata[7:0]});

	// Register writes; indexes past the list are ignored.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			key_q     <= '0;
			rounds_q  <= xtea_pkg::ROUNDS_RESET;
			dec_sum_q <= xtea_pkg::DEC_SUM_RESET;
		end else if (cfg_we) begin
			case (cfg_addr)
				xtea_pkg::REG_KEY_A: begin
					key_q[0] <= cfg_wdata;
				end
				xtea_pkg::REG_KEY_B: begin
					key_q[1] <= cfg_wdata;
				end
				xtea_pkg::REG_KEY_C: begin
					key_q[2] <= cfg_wdata;
				end
				xtea_pkg::REG_KEY_D: begin
					key_q[3] <= cfg_wdata;
				end
				xtea_pkg::REG_ROUNDS: begin
					rounds_q  <= cfg_wdata[7:0];
					dec_sum_q <= dec_sum_next;
				end
				default: begin
				end
			endcase
		end
	end

	assign cfg.key     = key_q;
	assign cfg.rounds  = rounds_q;
	assign cfg.dec_sum = dec_sum_q;

endmodule

### rtl/xtea_round.sv
// ----------------------------------------------------------------------------
// XTEA half-round unit
// One Feistel half-step: the mixed source word, XORed with sum plus key word,
// is added to or subtracted from the destination word.
// ----------------------------------------------------------------------------
module xtea_round (
	input  logic [31:0] src,
	input  logic [31:0] dst,
	input  logic [31:0] sum,
	input  logic [31:0] key_word,
	input  logic        subtract,
	output logic [31:0] res
);

	logic [31:0] mix;
	logic [31:0] key_term;
	logic [31:0] f_val;

	// Shift-XOR mix and key term run side by side, then one add or subtract.
	always_comb begin
		mix      = ((src << 4) ^ (src >> 5)) + src;
		key_term = sum + key_word;
		f_val    = mix ^ key_term;
		res      = subtract ? (dst - f_val) : (dst + f_val);
	end

endmodule

### rtl/xtea_block_cipher.sv
// ----------------------------------------------------------------------------
// XTEA block cipher
// Encrypts or decrypts one 64-bit block with a 128-bit key, one half-round
// per clock through a single shared half-round unit.
//
//   Channel   Direction  Contents
//   s_*       in         word: block halves on tdata, encrypt/decrypt on tuser
//   m_*       out        word: processed block halves on tdata
//   cfg_*     in         register writes: key words and round count
//
// From acceptance a block steps through the run state and then the flush
// state, which loads the result word; the shared half-round unit does one
// half-round per clock. A round count of 0 goes straight from idle to flush.
// s_tready is high only while no block is in work; a finished block waits in
// the work registers while the previous result word is still stalled.
// arst_n resets the sequencer, the output valid and the config registers.
// ----------------------------------------------------------------------------
`include "xtea_block_cipher_assert.svh"

module xtea_block_cipher (
	input  logic        clk,
	input  logic        arst_n,
	// Input word.
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [63:0] s_tdata,    // word_first [31:0], word_second [63:32]
	input  logic        s_tuser,    // req_type [0]
	// Output word.
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [63:0] m_tdata,    // out_first [31:0], out_second [63:32]
	// Configuration writes.
	input  logic        cfg_we,
	input  logic [2:0]  cfg_addr,
	input  logic [31:0] cfg_wdata
);

	typedef enum logic [2:0] {
		ST_IDLE  = 3'b001,
		ST_RUN   = 3'b010,
		ST_FLUSH = 3'b100
	} state_t;

	xtea_pkg::cfg_t cfg;

	state_t      state_q;
	logic        phase_q;
	logic        dec_q;
	logic [7:0]  rounds_left_q;
	logic [31:0] sum_q;
	logic [31:0] a_q;
	logic [31:0] b_q;
	logic        out_valid_q;
	logic [63:0] out_data_q;

	logic        accept;
	logic        out_free;
	logic        last_half;
	logic        target_a;
	logic [1:0]  key_sel;
	logic [31:0] hr_src;
	logic [31:0] hr_dst;
	logic [31:0] hr_res;

	xtea_cfg u_cfg (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_addr  (cfg_addr),
		.cfg_wdata (cfg_wdata),
		.cfg       (cfg)
	);

	// Handshake terms.
	assign s_tready  = (state_q == ST_IDLE);
	assign accept    = s_tvalid && s_tready;
	assign out_free  = !out_valid_q || m_tready;
	assign last_half = (state_q == ST_RUN) && phase_q && (rounds_left_q == 8'd1);

	// Operand routing: the first half-round of encryption updates a, that of
	// decryption updates b; the key index comes from the low sum bits when a
	// is updated and from bits 12:11 when b is updated.
	always_comb begin
		target_a = (~phase_q) ^ dec_q;
		key_sel  = target_a ? sum_q[1:0] : sum_q[12:11];
		hr_src   = target_a ? b_q : a_q;
		hr_dst   = target_a ? a_q : b_q;
	end

	xtea_round u_round (
		.src      (hr_src),
		.dst      (hr_dst),
		.sum      (sum_q),
		.key_word (cfg.key[key_sel]),
		.subtract (dec_q),
		.res      (hr_res)
	);

	// Sequencer and output valid.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q       <= ST_IDLE;
			phase_q       <= 1'b0;
			rounds_left_q <= '0;
			out_valid_q   <= 1'b0;
		end else begin
			if ((state_q == ST_FLUSH) && out_free) begin
				out_valid_q <= 1'b1;
			end else if (m_tready) begin
				out_valid_q <= 1'b0;
			end
			case (state_q)
				ST_IDLE: begin
					if (accept) begin
						phase_q       <= 1'b0;
						rounds_left_q <= cfg.rounds;
						state_q       <= (cfg.rounds == 8'd0) ? ST_FLUSH : ST_RUN;
					end
				end
				ST_RUN: begin
					phase_q <= ~phase_q;
					if (phase_q) begin
						rounds_left_q <= rounds_left_q - 8'd1;
					end
					if (last_half) begin
						state_q <= ST_FLUSH;
					end
				end
				ST_FLUSH: begin
					if (out_free) begin
						state_q <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	// Block halves, running sum and result word.
	always_ff @(posedge clk) begin
		if (accept) begin
			dec_q <= (s_tuser == xtea_pkg::REQ_DECRYPT);
			a_q   <= s_tdata[31:0];
			b_q   <= s_tdata[63:32];
			sum_q <= (s_tuser == xtea_pkg::REQ_DECRYPT) ? cfg.dec_sum : 32'd0;
		end else if (state_q == ST_RUN) begin
			if (target_a) begin
				a_q <= hr_res;
			end else begin
				b_q <= hr_res;
			end
			// The sum moves between the two half-rounds of a cycle.
			if (!phase_q) begin
				sum_q <= dec_q ? (sum_q - xtea_pkg::XTEA_DELTA)
				               : (sum_q + xtea_pkg::XTEA_DELTA);
			end
		end
		if ((state_q == ST_FLUSH) && out_free) begin
			out_data_q <= {b_q, a_q};
		end
	end

	assign m_tvalid = out_valid_q;
	assign m_tdata  = out_data_q;

	// Checks on the sequencer.
	`XTEA_ASSERT_NEXT(a_zero_rounds, accept && (cfg.rounds == 8'd0), state_q == ST_FLUSH, "zero-round block did not go straight to flush")
	`XTEA_ASSERT_NEXT(a_last_half, last_half, state_q == ST_FLUSH, "run did not end after the last half-round")
	`XTEA_ASSERT(a_run_count, (state_q != ST_RUN) || (rounds_left_q != 8'd0), "running with no rounds left")
	`XTEA_ASSERT(a_load_from_flush, !$rose(m_tvalid) || ($past(state_q) == ST_FLUSH), "result word raised outside flush")

endmodule
